/* rtl/core/tss_pkg.sv */
// Package for the tile span splitter.
// Holds the request and response word types, controller command and status structs,
// and fixed datapath widths. Depends on nothing.
`default_nettype none

package tss_pkg;

   localparam int unsigned DIVIDEND_W = 17;
   localparam int unsigned REM_W      = 16;
   localparam int unsigned ACC_W      = 20;
   localparam int unsigned DIV_STEPS  = 1;
   localparam int unsigned CNT_W      = 1;

   typedef struct packed {
      logic [15:0] top_row;
      logic [16:0] left_col;
      logic [15:0] bottom_row;
      logic [16:0] right_col;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  tile_h;
      logic [4:0]  tile_v;
      logic [11:0] src_row;
      logic [11:0] src_col;
      logic [11:0] span_rows;
      logic [11:0] span_cols;
      logic [15:0] dst_row;
      logic [16:0] dst_col;
      logic        region_bad;
      logic        last_piece;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic walk_start;
      logic next_v;
      logic next_h;
   } tss_cmd_type;

   typedef struct packed {
      logic bad;
      logic last_v;
      logic last_h;
   } tss_status_type;

endpackage

`default_nettype wire

/* rtl/core/tile_span_splitter_unit.sv */
// Top level of the tile span splitter: joins the controller and the datapath.
// Depends on tss_pkg, tss_ctrl and tss_datapath.
`default_nettype none

// Each request word describes an inclusive rectangle of the global grid and yields one
// response word per tile it touches, walking tiles column by column and, within a column,
// top to bottom; the final word carries last_piece. A region that is inverted, spans more
// than MAX_SPAN tiles in either direction, or reaches past the tile grid yields a single word
// with region_bad and last_piece set and all other fields zero. One region is handled at a
// time: at acceptance the four corner coordinates are multiplied by the reciprocal of the
// tile size, and in the next cycle the quotients and remainders are formed. Response words
// are offered in the walk state, which follows that divide state, and one goes out per cycle
// unless stalled; the next request word is taken only after the last word of a region of
// n tiles (up to MAX_SPAN squared) has gone out.
module tile_span_splitter_unit
   import tss_pkg::*;
#(
   parameter int unsigned TILE_ROWS    = 2400,
   parameter int unsigned TILE_COLS    = 2400,
   parameter int unsigned TILES_DOWN   = 18,
   parameter int unsigned TILES_ACROSS = 36,
   parameter int unsigned MAX_SPAN     = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   tss_cmd_type    cmd;
   tss_status_type status;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tss_datapath #(
      .TILE_ROWS    (TILE_ROWS),
      .TILE_COLS    (TILE_COLS),
      .TILES_DOWN   (TILES_DOWN),
      .TILES_ACROSS (TILES_ACROSS),
      .MAX_SPAN     (MAX_SPAN)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/tss_div_lane.sv */
// One divider lane: divides a loaded value by a constant through a reciprocal multiplication.
// The product is taken on load and quotient and remainder on the following step. Uses tss_pkg.
`default_nettype none

module tss_div_lane
   import tss_pkg::*;
#(
   parameter int unsigned DIVISOR = 2400
) (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic                  step,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   output logic      [DIVIDEND_W-1:0] quotient,
   output logic      [REM_W-1:0]      remainder
);

   localparam int unsigned SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
   localparam int unsigned RECIP_W = DIVIDEND_W + 1;
   localparam int unsigned PROD_W  = DIVIDEND_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0]    RECIP   = RECIP_W'(RECIP_FULL);
   localparam logic [DIVIDEND_W-1:0] DIV_VAL = DIVIDEND_W'(DIVISOR);

   logic [DIVIDEND_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]     p_ff, p_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [REM_W-1:0]      r_ff, r_in;
   logic [DIVIDEND_W-1:0] q_calc, q_back;

   always_comb begin
      q_calc = DIVIDEND_W'(p_ff >> SHIFT);
      q_back = q_calc * DIV_VAL;
      x_in   = x_ff;
      p_in   = p_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      if (load) begin
         x_in = dividend;
         p_in = PROD_W'(dividend) * PROD_W'(RECIP);
      end else if (step) begin
         q_in = q_calc;
         r_in = REM_W'(x_ff - q_back);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      p_ff <= p_in;
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

/* rtl/core/tss_datapath.sv */
// Datapath of the tile span splitter: four divider lanes, region checks, tile walk
// counters and destination accumulators. Depends on tss_pkg and tss_div_lane.
`default_nettype none

module tss_datapath
   import tss_pkg::*;
#(
   parameter int unsigned TILE_ROWS    = 2400,
   parameter int unsigned TILE_COLS    = 2400,
   parameter int unsigned TILES_DOWN   = 18,
   parameter int unsigned TILES_ACROSS = 36,
   parameter int unsigned MAX_SPAN     = 4
) (
   input  wire logic           clock,
   input  wire tss_cmd_type    cmd,
   input  wire req_word_type   req_data,
   output tss_status_type      status,
   output rsp_word_type        rsp_data
);

   localparam int unsigned OFS_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
   localparam logic [DIVIDEND_W-1:0] SPAN_LIM   = DIVIDEND_W'(MAX_SPAN);
   localparam logic [DIVIDEND_W-1:0] DOWN_LIM   = DIVIDEND_W'(TILES_DOWN);
   localparam logic [DIVIDEND_W-1:0] ACROSS_LIM = DIVIDEND_W'(TILES_ACROSS);
   localparam logic [REM_W-1:0]      ROW_END    = REM_W'(TILE_ROWS - 1);
   localparam logic [REM_W-1:0]      COL_END    = REM_W'(TILE_COLS - 1);

   req_word_type          req_ff;
   logic [DIVIDEND_W-1:0] v1, h1, v3, h3;
   logic [REM_W-1:0]      r1, c1, r3, c3;
   logic [OFS_W-1:0]      dv_ff, dv_in, dh_ff, dh_in;
   logic [ACC_W-1:0]      dr_ff, dr_in, dc_ff, dc_in;
   logic                  inverted, too_wide, outside, first_v, first_h;
   logic [REM_W-1:0]      sr, er, sc, ec;
   logic [DIVIDEND_W-1:0] span_r, span_c, tile_h_full, tile_v_full;

   tss_div_lane #(.DIVISOR(TILE_ROWS)) u_top (
      .clock(clock), .load(cmd.load), .step(cmd.div_step),
      .dividend({1'b0, req_data.top_row}), .quotient(v1), .remainder(r1));
   tss_div_lane #(.DIVISOR(TILE_COLS)) u_left (
      .clock(clock), .load(cmd.load), .step(cmd.div_step),
      .dividend(req_data.left_col), .quotient(h1), .remainder(c1));
   tss_div_lane #(.DIVISOR(TILE_ROWS)) u_bottom (
      .clock(clock), .load(cmd.load), .step(cmd.div_step),
      .dividend({1'b0, req_data.bottom_row}), .quotient(v3), .remainder(r3));
   tss_div_lane #(.DIVISOR(TILE_COLS)) u_right (
      .clock(clock), .load(cmd.load), .step(cmd.div_step),
      .dividend(req_data.right_col), .quotient(h3), .remainder(c3));

   always_comb begin
      inverted = (req_ff.top_row > req_ff.bottom_row) || (req_ff.left_col > req_ff.right_col);
      too_wide = ((h3 - h1) >= SPAN_LIM) || ((v3 - v1) >= SPAN_LIM);
      outside  = (h3 >= ACROSS_LIM) || (v3 >= DOWN_LIM);

      status.bad    = inverted || too_wide || outside;
      status.last_v = (DIVIDEND_W'(dv_ff) == (v3 - v1));
      status.last_h = (DIVIDEND_W'(dh_ff) == (h3 - h1));

      first_v = (dv_ff == '0);
      first_h = (dh_ff == '0);
      sr = first_v ? r1 : '0;
      er = status.last_v ? r3 : ROW_END;
      sc = first_h ? c1 : '0;
      ec = status.last_h ? c3 : COL_END;
      span_r = {1'b0, er} - {1'b0, sr} + DIVIDEND_W'(1);
      span_c = {1'b0, ec} - {1'b0, sc} + DIVIDEND_W'(1);
      tile_h_full = h1 + DIVIDEND_W'(dh_ff);
      tile_v_full = v1 + DIVIDEND_W'(dv_ff);

      dv_in = dv_ff;
      dh_in = dh_ff;
      dr_in = dr_ff;
      dc_in = dc_ff;
      if (cmd.walk_start) begin
         dv_in = '0;
         dh_in = '0;
         dr_in = '0;
         dc_in = '0;
      end else if (cmd.next_h) begin
         dv_in = '0;
         dh_in = dh_ff + OFS_W'(1);
         dr_in = '0;
         dc_in = dc_ff + ACC_W'(span_c);
      end else if (cmd.next_v) begin
         dv_in = dv_ff + OFS_W'(1);
         dr_in = dr_ff + ACC_W'(span_r);
      end

      if (status.bad) begin
         rsp_data            = '0;
         rsp_data.region_bad = 1'b1;
         rsp_data.last_piece = 1'b1;
      end else begin
         rsp_data.tile_h     = 6'(tile_h_full);
         rsp_data.tile_v     = 5'(tile_v_full);
         rsp_data.src_row    = 12'(sr);
         rsp_data.src_col    = 12'(sc);
         rsp_data.span_rows  = 12'(span_r);
         rsp_data.span_cols  = 12'(span_c);
         rsp_data.dst_row    = 16'(dr_ff);
         rsp_data.dst_col    = 17'(dc_ff);
         rsp_data.region_bad = 1'b0;
         rsp_data.last_piece = status.last_v && status.last_h;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      dv_ff <= dv_in;
      dh_ff <= dh_in;
      dr_ff <= dr_in;
      dc_ff <= dc_in;
   end

endmodule

`default_nettype wire

/* rtl/core/tss_ctrl.sv */
// Controller of the tile span splitter: sequences loading, division steps and the tile walk.
// Depends on tss_pkg.
`default_nettype none

module tss_ctrl
   import tss_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire tss_status_type status,
   output tss_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WALK
   } state_type;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!rsp_stall) begin
               priority if (status.bad || (status.last_v && status.last_h)) begin
                  state_in = ST_IDLE;
               end else if (status.last_v) begin
                  cmd.next_h = 1'b1;
               end else begin
                  cmd.next_v = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_WALK);

endmodule

`default_nettype wire
